@@ hdl/stsr_pkg.sv @@
// ---------------------------------------------------------------------------
// Stream timestamp rebaser package
// Item types, table entry layout and fixed constants shared by the block.
// ---------------------------------------------------------------------------
package stsr_pkg;

  typedef logic signed [47:0] ts_t;
  typedef logic signed [24:0] avg_t;

  // one packet header
  typedef struct packed {
    logic [15:0]        stream_id;
    logic               is_audio_stream;
    logic               routed;
    logic signed [47:0] present_time;
    logic               present_valid;
    logic signed [47:0] decode_time;
    logic               decode_valid;
    logic [15:0]        scr_change_count;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [2:0]         status;
    logic signed [47:0] present_out;
    logic               present_out_valid;
    logic signed [47:0] decode_out;
    logic               decode_out_valid;
    logic [31:0]        sequence_number;
  } out_item_t;

  // one row of the stream table
  typedef struct packed {
    logic [15:0] stream_id;
    avg_t        average;
    ts_t         last_time;
    logic        audio;
    logic        timing_valid;
  } entry_t;

  // result status codes
  localparam logic [2:0] ST_FORWARDED     = 3'd0;
  localparam logic [2:0] ST_UNROUTED      = 3'd1;
  localparam logic [2:0] ST_BEFORE_ZERO   = 3'd2;
  localparam logic [2:0] ST_BEFORE_START  = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL    = 3'd4;

  // configuration register indexes
  localparam int         CFG_IDX_W        = 2;
  localparam logic [1:0] CFG_VIDEO_ID     = 2'd0;
  localparam logic [1:0] CFG_VIDEO_PERIOD = 2'd1;
  localparam logic [1:0] CFG_START_POINT  = 2'd2;
  localparam int         CFG_DATA_W       = 47;

  localparam logic [15:0] VIDEO_ID_RST    = 16'd224;
  localparam logic [23:0] PERIOD_RST      = 24'd96096;

  // new entry: 30 ms average (1/32 tick units), last time one period back
  localparam avg_t              NEW_AVG    = 25'sd86400;
  localparam ts_t               NEW_LAST   = -48'sd2700;
  localparam logic signed [48:0] JUMP_LIMIT = 49'sd450000;

endpackage

@@ hdl/stsr_chan_if.sv @@
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of type T.
// ---------------------------------------------------------------------------
interface stsr_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/stsr_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module stsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/stream_timestamp_rebaser_core.sv @@
// ---------------------------------------------------------------------------
// Stream timestamp rebaser core
// Per-stream table in RAM, rebasing of timestamps across clock changes.
// ---------------------------------------------------------------------------
// One item is handled at a time: a linear search of the stream table (one
// RAM read per entry) followed by a fixed read-modify-write sequence.
// Unrouted and pre-start-of-time items skip the search and that sequence.
// The next item is taken while a result still waits on the output. After
// reset, and after a write of the video frame period, entry zero is
// reloaded before any item is taken.
module stream_timestamp_rebaser_core
  import stsr_pkg::*;
#(
  parameter int MAX_STREAMS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  stsr_chan_if.sink             in_chan,
  stsr_chan_if.source           out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_STREAMS);
  localparam int CW = $clog2(MAX_STREAMS + 1);
  localparam int EW = $bits(entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_OFS  = 3'd4;
  localparam logic [2:0] S_TS   = 3'd5;
  localparam logic [2:0] S_FLT  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // control and global state
  logic [2:0]    state_r, state_nxt;
  logic          pend0_r, pend0_nxt;
  logic [CW-1:0] count_r, count_nxt;
  ts_t           offset_r, offset_nxt;
  logic [15:0]   scrs_r, scrs_nxt;
  logic          sf_r, sf_nxt;
  logic          sa_r, sa_nxt;
  logic          sr_r, sr_nxt;
  logic [31:0]   fwd_r, fwd_nxt;
  logic [15:0]   vid_r;
  logic [23:0]   vfp_r;
  logic [46:0]   start_r;

  // per-item working registers
  in_item_t      it_r;
  logic          pv_r, pv_nxt;
  logic          dv_r, dv_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  avg_t          e_avg_r, e_avg_nxt;
  ts_t           e_last_r, e_last_nxt;
  logic          e_aud_r, e_aud_nxt;
  logic          e_tv_r, e_tv_nxt;
  ts_t           last0_r, last0_nxt;
  ts_t           lastsel_r, lastsel_nxt;
  logic          go_r, go_nxt;
  ts_t           pout_r, pout_nxt;
  ts_t           dout_r, dout_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [31:0]   res_seq_r, res_seq_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // table RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;
  logic [EW-1:0] ram_rbits;

  assign ram_rdata = entry_t'(ram_rbits);

  stsr_ram #(.WIDTH(EW), .DEPTH(MAX_STREAMS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  logic in_fire;
  assign in_chan.ready  = (state_r == S_IDLE) && !pend0_r;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // next-state logic
  always_comb begin
    logic                match;
    logic                need_add;
    logic                sa_v;
    logic [15:0]         scrs_v;
    logic signed [53:0]  s;
    logic signed [53:0]  sn;
    ts_t                 nx;
    ts_t                 pout_v;
    logic signed [48:0]  dt;
    logic signed [25:0]  navg;
    logic signed [25:0]  shv;
    logic [25:0]         upd;
    avg_t                avg_v;
    ts_t                 last_v;

    state_nxt      = state_r;
    pend0_nxt      = pend0_r;
    count_nxt      = count_r;
    offset_nxt     = offset_r;
    scrs_nxt       = scrs_r;
    sf_nxt         = sf_r;
    sa_nxt         = sa_r;
    sr_nxt         = sr_r;
    fwd_nxt        = fwd_r;
    pv_nxt         = pv_r;
    dv_nxt         = dv_r;
    ptr_nxt        = ptr_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    idx_nxt        = idx_r;
    e_avg_nxt      = e_avg_r;
    e_last_nxt     = e_last_r;
    e_aud_nxt      = e_aud_r;
    e_tv_nxt       = e_tv_r;
    last0_nxt      = last0_r;
    lastsel_nxt    = lastsel_r;
    go_nxt         = go_r;
    pout_nxt       = pout_r;
    dout_nxt       = dout_r;
    res_status_nxt = res_status_r;
    res_seq_nxt    = res_seq_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = ptr_r[IW-1:0];

    match    = 1'b0;
    need_add = 1'b0;
    sa_v     = sa_r;
    scrs_v   = scrs_r;
    s        = '0;
    sn       = '0;
    nx       = '0;
    pout_v   = '0;
    dt       = '0;
    navg     = '0;
    shv      = '0;
    upd      = '0;
    avg_v    = e_avg_r;
    last_v   = e_last_r;

    case (state_r)
      S_IDLE: begin
        // reload entry zero from the video registers
        if (pend0_r) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = '{stream_id: vid_r, average: avg_t'({1'b0, vfp_r}),
                        last_time: ts_t'(-$signed({29'b0, vfp_r[23:5]})),
                        audio: 1'b0, timing_valid: 1'b1};
          pend0_nxt = 1'b0;
        end else if (in_fire) begin
          pv_nxt    = in_chan.data.present_valid;
          dv_nxt    = in_chan.data.decode_valid;
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        // early drops
        ptr_nxt     = '0;
        chk_vld_nxt = 1'b0;
        if (!it_r.routed) begin
          res_status_nxt = ST_UNROUTED;
          state_nxt      = S_EMIT;
        end else if (!sf_r && !(it_r.present_valid && it_r.decode_valid &&
                     (it_r.stream_id == vid_r || it_r.is_audio_stream))) begin
          res_status_nxt = ST_BEFORE_ZERO;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_SRCH;
        end
      end

      S_SRCH: begin
        // linear search, one read issued and one compared each cycle
        match = (chk_idx_r == '0) ? (it_r.stream_id == vid_r)
                                  : (ram_rdata.stream_id == it_r.stream_id);
        if (chk_vld_r && chk_idx_r == '0) begin
          last0_nxt = ram_rdata.last_time;
        end
        if (chk_vld_r && match) begin
          found_nxt  = 1'b1;
          idx_nxt    = chk_idx_r;
          e_avg_nxt  = ram_rdata.average;
          e_last_nxt = ram_rdata.last_time;
          e_aud_nxt  = ram_rdata.audio;
          e_tv_nxt   = ram_rdata.timing_valid;
          state_nxt  = S_DEC;
        end else if (ptr_r >= count_r) begin
          found_nxt = 1'b0;
          state_nxt = S_DEC;
        end else begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = ptr_r[IW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end
      end

      S_DEC: begin
        if (it_r.decode_valid && !found_r && count_r >= CW'(MAX_STREAMS)) begin
          res_status_nxt = ST_TABLE_FULL;
          state_nxt      = S_EMIT;
        end else begin
          // first packet arms the clock change count
          if (!sf_r) begin
            scrs_v = it_r.scr_change_count - 16'd1;
          end
          sf_nxt   = 1'b1;
          scrs_nxt = scrs_v;
          // only one new entry per item, whichever path needs it
          need_add = !found_r && (it_r.decode_valid || !sf_r);
          if (need_add) begin
            idx_nxt    = count_r[IW-1:0];
            count_nxt  = count_r + CW'(1);
            found_nxt  = 1'b1;
            e_avg_nxt  = NEW_AVG;
            e_last_nxt = NEW_LAST;
            e_aud_nxt  = it_r.is_audio_stream;
            e_tv_nxt   = !sf_r || (scrs_r == it_r.scr_change_count);
            sa_v       = sa_r | it_r.is_audio_stream;
          end
          sa_nxt = sa_v;
          go_nxt = 1'b0;
          // clock change: pick a new offset or strip the timestamps
          if (it_r.decode_valid && scrs_v != it_r.scr_change_count) begin
            if (e_aud_nxt || (idx_nxt == '0 && !sa_v)) begin
              go_nxt      = 1'b1;
              lastsel_nxt = e_tv_nxt ? e_last_nxt : last0_r;
              e_tv_nxt    = 1'b1;
            end else begin
              pv_nxt = 1'b0;
              dv_nxt = 1'b0;
            end
          end
          state_nxt = S_OFS;
        end
      end

      S_OFS: begin
        // next = trunc((last*32 + average) / 32)
        if (go_r) begin
          s  = $signed({lastsel_r[47], lastsel_r, 5'b0}) +
               $signed({{29{e_avg_r[24]}}, e_avg_r});
          sn = s[53] ? (s + 54'sd31) : s;
          nx = ts_t'(sn >>> 5);
          offset_nxt = it_r.decode_time - nx;
          scrs_nxt   = it_r.scr_change_count;
          e_last_nxt = nx;
        end
        state_nxt = S_TS;
      end

      S_TS: begin
        // rebased times and start point
        pout_v   = it_r.present_time - offset_r;
        pout_nxt = pout_v;
        dout_nxt = it_r.decode_time - offset_r;
        if (pv_r && !sr_r && pout_v >= $signed({1'b0, start_r})) begin
          sr_nxt = 1'b1;
        end
        dv_nxt    = dv_r && (scrs_r == it_r.scr_change_count);
        state_nxt = S_FLT;
      end

      S_FLT: begin
        // 1/32 low-pass of the inter-packet time, then write back
        if (dv_r) begin
          dt = $signed({dout_r[47], dout_r}) - $signed({e_last_r[47], e_last_r});
          if (dt > -JUMP_LIMIT && dt < JUMP_LIMIT) begin
            navg   = -$signed({e_avg_r[24], e_avg_r});
            shv    = navg >>> 5;
            upd    = {e_avg_r[24], e_avg_r} + dt[25:0] + shv;
            avg_v  = avg_t'(upd[24:0]);
            last_v = dout_r;
          end
        end
        e_avg_nxt  = avg_v;
        e_last_nxt = last_v;
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = '{stream_id: it_r.stream_id, average: avg_v, last_time: last_v,
                        audio: e_aud_r, timing_valid: e_tv_r || dv_r};
        end
        if (!sr_r) begin
          res_status_nxt = ST_BEFORE_START;
        end else begin
          res_status_nxt = ST_FORWARDED;
          res_seq_nxt    = fwd_r;
          fwd_nxt        = fwd_r + 32'd1;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // hand the result to the output register
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = res_status_r;
          if (res_status_r == ST_FORWARDED) begin
            out_data_nxt.present_out       = pv_r ? pout_r : '0;
            out_data_nxt.present_out_valid = pv_r;
            out_data_nxt.decode_out        = dv_r ? dout_r : '0;
            out_data_nxt.decode_out_valid  = dv_r;
            out_data_nxt.sequence_number   = res_seq_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes to control state: user, only while idle; unchecked
    if (cfg_we) begin
      case (cfg_index)
        CFG_VIDEO_PERIOD: begin
          pend0_nxt = 1'b1;
        end
        CFG_START_POINT: begin
          sr_nxt = (cfg_data == '0);
        end
        default: begin
        end
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend0_r     <= 1'b1;
      count_r     <= CW'(1);
      offset_r    <= '0;
      scrs_r      <= '0;
      sf_r        <= 1'b0;
      sa_r        <= 1'b0;
      sr_r        <= 1'b1;
      fwd_r       <= '0;
      vid_r       <= VIDEO_ID_RST;
      vfp_r       <= PERIOD_RST;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend0_r     <= pend0_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      scrs_r      <= scrs_nxt;
      sf_r        <= sf_nxt;
      sa_r        <= sa_nxt;
      sr_r        <= sr_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      // configuration registers
      if (cfg_we) begin
        case (cfg_index)
          CFG_VIDEO_ID: begin
            vid_r <= cfg_data[15:0];
          end
          CFG_VIDEO_PERIOD: begin
            vfp_r <= cfg_data[23:0];
          end
          CFG_START_POINT: begin
            start_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_r <= in_chan.data;
    end
    pv_r         <= pv_nxt;
    dv_r         <= dv_nxt;
    ptr_r        <= ptr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_r      <= found_nxt;
    idx_r        <= idx_nxt;
    e_avg_r      <= e_avg_nxt;
    e_last_r     <= e_last_nxt;
    e_aud_r      <= e_aud_nxt;
    e_tv_r       <= e_tv_nxt;
    last0_r      <= last0_nxt;
    lastsel_r    <= lastsel_nxt;
    go_r         <= go_nxt;
    pout_r       <= pout_nxt;
    dout_r       <= dout_nxt;
    res_status_r <= res_status_nxt;
    res_seq_r    <= res_seq_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// Stream timestamp rebaser testbench
// Drives packet headers through the core with random idling on both sides,
// predicts each result from a behavioural copy of the stream table and
// checks every result field by field.
// ---------------------------------------------------------------------------
module tb_top
  import stsr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STREAMS = 16;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stsr_chan_if #(.T(in_item_t))  in_chan ();
  stsr_chan_if #(.T(out_item_t)) out_chan ();

  stream_timestamp_rebaser_core #(.MAX_STREAMS(NUM_STREAMS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of configuration and stream table
  logic [15:0] vid_id;
  logic [23:0] vid_period;
  logic [46:0] start_pt;
  logic [15:0] tbl_id    [NUM_STREAMS];
  longint      tbl_avg   [NUM_STREAMS];
  longint      tbl_last  [NUM_STREAMS];
  bit          tbl_audio [NUM_STREAMS];
  bit          tbl_tv    [NUM_STREAMS];
  int          tbl_cnt;
  longint      rebase_ofs;
  logic [15:0] scr_seen;
  bit          first_seen;
  bit          audio_seen;
  bit          start_hit;
  logic [31:0] fwd_cnt;

  out_item_t expected_results[$];
  int        err_cnt;
  bit        idling;
  int        hold_left;
  int        stall_left;

  // stimulus state
  logic [15:0] id_pool [6];
  longint      tbase;
  logic [15:0] scr_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("** stream_timestamp_rebaser_core: FAILED **");
    $finish;
  end

  function automatic longint wrap48(longint x);
    logic signed [47:0] t;
    t = x[47:0];
    return longint'(t);
  endfunction

  function automatic longint floor_div32(longint d);
    if (d >= 0) return d / 32;
    return -((-d + 31) / 32);
  endfunction

  function automatic void load_video_entry();
    tbl_id[0]    = vid_id;
    tbl_avg[0]   = longint'({40'd0, vid_period});
    tbl_last[0]  = -longint'({45'd0, vid_period[23:5]});
    tbl_audio[0] = 1'b0;
    tbl_tv[0]    = 1'b1;
  endfunction

  function automatic int add_stream(logic [15:0] id, bit aud, bit tv);
    int i;
    i = tbl_cnt;
    tbl_id[i]    = id;
    tbl_avg[i]   = longint'(NEW_AVG);
    tbl_last[i]  = longint'(NEW_LAST);
    tbl_audio[i] = aud;
    tbl_tv[i]    = tv;
    if (aud) audio_seen = 1'b1;
    tbl_cnt = i + 1;
    return i;
  endfunction

  // expected result of one packet; updates the predictor state
  function automatic out_item_t rebase_packet(in_item_t p);
    out_item_t r;
    int        idx;
    longint    pts, dts, pout, dout, lst, nxt, dt;
    bit        pv, dv;
    r    = '0;
    pts  = longint'(p.present_time);
    dts  = longint'(p.decode_time);
    pv   = p.present_valid;
    dv   = p.decode_valid;
    pout = 0;
    dout = 0;
    if (!p.routed) begin
      r.status = ST_UNROUTED;
      return r;
    end
    if (!first_seen && !(pv && dv && (p.stream_id == vid_id || p.is_audio_stream))) begin
      r.status = ST_BEFORE_ZERO;
      return r;
    end
    idx = -1;
    for (int i = tbl_cnt - 1; i >= 0; i--)
      if (tbl_id[i] == p.stream_id) idx = i;
    if (dv && idx < 0 && tbl_cnt >= NUM_STREAMS) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    if (!first_seen) begin
      scr_seen = p.scr_change_count - 16'd1;
      if (idx < 0) idx = add_stream(p.stream_id, p.is_audio_stream, 1'b1);
      first_seen = 1'b1;
    end
    // clock change: audio (or video before audio) sets a new offset
    if (dv && scr_seen != p.scr_change_count) begin
      if (idx < 0) idx = add_stream(p.stream_id, p.is_audio_stream, 1'b0);
      if (tbl_audio[idx] || (idx == 0 && !audio_seen)) begin
        if (!tbl_tv[idx]) begin
          lst = tbl_last[0];
          tbl_tv[idx] = 1'b1;
        end else begin
          lst = tbl_last[idx];
        end
        nxt = (lst * 32 + tbl_avg[idx]) / 32;
        rebase_ofs = wrap48(dts - nxt);
        scr_seen = p.scr_change_count;
        tbl_last[idx] = wrap48(nxt);
      end else begin
        pv = 1'b0;
        dv = 1'b0;
      end
    end
    if (pv) begin
      pout = wrap48(pts - rebase_ofs);
      if (!start_hit && pout >= longint'({17'd0, start_pt})) start_hit = 1'b1;
    end
    // average filter, large jumps ignored
    if (dv && scr_seen == p.scr_change_count) begin
      dout = wrap48(dts - rebase_ofs);
      if (idx < 0) idx = add_stream(p.stream_id, p.is_audio_stream, 1'b1);
      dt = dout - tbl_last[idx];
      if (dt > -longint'(JUMP_LIMIT) && dt < longint'(JUMP_LIMIT)) begin
        tbl_avg[idx] += floor_div32(dt * 32 - tbl_avg[idx]);
        tbl_last[idx] = dout;
      end
      tbl_tv[idx] = 1'b1;
    end else begin
      dv = 1'b0;
    end
    if (!start_hit) begin
      r.status = ST_BEFORE_START;
      return r;
    end
    r.status            = ST_FORWARDED;
    r.present_out       = pv ? pout[47:0] : '0;
    r.present_out_valid = pv;
    r.decode_out        = dv ? dout[47:0] : '0;
    r.decode_out_valid  = dv;
    r.sequence_number   = fwd_cnt;
    fwd_cnt++;
    return r;
  endfunction

  // accepted items in, results out and checked
  always @(posedge clk) begin
    out_item_t e, a;
    if (rst_n && in_chan.valid && in_chan.ready)
      expected_results.push_back(rebase_packet(in_chan.data));
    if (rst_n && out_chan.valid && out_chan.ready) begin
      a = out_chan.data;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d", a.status);
        err_cnt++;
      end else begin
        e = expected_results.pop_front();
        if (a.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, a.status);
          err_cnt++;
        end
        if (a.present_out !== e.present_out) begin
          $error("present_out: expected %0d, got %0d", e.present_out, a.present_out);
          err_cnt++;
        end
        if (a.present_out_valid !== e.present_out_valid) begin
          $error("present_out_valid: expected %0b, got %0b",
                 e.present_out_valid, a.present_out_valid);
          err_cnt++;
        end
        if (a.decode_out !== e.decode_out) begin
          $error("decode_out: expected %0d, got %0d", e.decode_out, a.decode_out);
          err_cnt++;
        end
        if (a.decode_out_valid !== e.decode_out_valid) begin
          $error("decode_out_valid: expected %0b, got %0b",
                 e.decode_out_valid, a.decode_out_valid);
          err_cnt++;
        end
        if (a.sequence_number !== e.sequence_number) begin
          $error("sequence_number: expected %0d, got %0d",
                 e.sequence_number, a.sequence_number);
          err_cnt++;
        end
      end
    end
  end

  // receiver: long hold-offs and random stall bursts
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        out_chan.ready = 1'b0;
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  task automatic send_item(in_item_t it);
    if (idling && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 15)) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_chan.valid = 1'b1;
    in_chan.data  = it;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // wait until every expected result is back and the core is quiet
  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_VIDEO_ID: begin
        vid_id     = val[15:0];
        tbl_id[0]  = vid_id;
        id_pool[0] = vid_id;
      end
      CFG_VIDEO_PERIOD: begin
        vid_period = val[23:0];
        load_video_entry();
      end
      CFG_START_POINT: begin
        start_pt  = val[46:0];
        start_hit = (val[46:0] == '0);
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
    repeat (4) @(negedge clk);
  endtask

  function automatic in_item_t pkt(logic [15:0] id, bit aud, bit rt, longint pts, bit pv,
                                   longint dts, bit dv, logic [15:0] scr);
    in_item_t it;
    it.stream_id        = id;
    it.is_audio_stream  = aud;
    it.routed           = rt;
    it.present_time     = pts[47:0];
    it.present_valid    = pv;
    it.decode_time      = dts[47:0];
    it.decode_valid     = dv;
    it.scr_change_count = scr;
    return it;
  endfunction

  // mostly well-formed packet flow with clock changes, some pure noise
  task automatic run_traffic(int n, int noise_pct);
    in_item_t it;
    int       s;
    bit       pv;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        it = pkt(16'($urandom), 1'($urandom), 1'($urandom), {$urandom, $urandom},
                 1'($urandom), {$urandom, $urandom}, 1'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(0, 24) == 0) begin
          scr_cnt++;
          if ($urandom_range(0, 1)) tbase += longint'($urandom_range(0, 900000)) - 450000;
          else tbase = {$urandom, $urandom};
        end
        tbase += $urandom_range(0, 3000);
        s  = $urandom_range(0, 5);
        pv = ($urandom_range(0, 9) != 0);
        it = pkt(id_pool[s], (s == 1 || s == 2), ($urandom_range(0, 19) != 0),
                 tbase + $urandom_range(0, 6000), pv, tbase,
                 pv && ($urandom_range(0, 7) != 0), scr_cnt);
      end
      send_item(it);
    end
  endtask

  // before time zero: dropped until video or audio carries both stamps
  task automatic test_time_zero();
    send_item(pkt(16'hFFFF, 1'b0, 1'b0, 64'sh7FFF_FFFF_FFFF, 1'b1,
                  64'sh8000_0000_0000, 1'b1, 16'd0));
    send_item(pkt(16'h0000, 1'b0, 1'b1, 64'sd1000, 1'b1, 64'sd900, 1'b1, 16'hFFFF));
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sd1000, 1'b1, 64'sd900, 1'b0, 16'd0));
    send_item(pkt(id_pool[1], 1'b1, 1'b1, 64'sd1000, 1'b0, 64'sd900, 1'b1, 16'd0));
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sd5000, 1'b1, 64'sd2000, 1'b1, 16'd0));
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sd8000, 1'b1, 64'sd5000, 1'b1, 16'd0));
    // new clock: video before any audio sets the offset
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sh7FFF_FFFF_FFFF, 1'b1,
                  -64'sh8000_0000_0000, 1'b1, 16'd1));
    send_item(pkt(id_pool[3], 1'b0, 1'b1, 64'sd9000, 1'b1, 64'sd9000, 1'b1, 16'd1));
    // audio sets the offset from now on; others lose stamps after a change
    send_item(pkt(id_pool[1], 1'b1, 1'b1, 64'sd12000, 1'b1, 64'sd11000, 1'b1, 16'd1));
    send_item(pkt(id_pool[4], 1'b0, 1'b1, 64'sd20000, 1'b1, 64'sd19000, 1'b1, 16'd2));
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sd20000, 1'b1, 64'sd19000, 1'b1, 16'd2));
    send_item(pkt(id_pool[2], 1'b1, 1'b1, 64'sd30000, 1'b1, 64'sd29000, 1'b1, 16'd2));
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sd40000, 1'b1, 64'sd31000, 1'b1, 16'd2));
    // jump beyond the filter limit, then present-only and stamp-free items
    send_item(pkt(id_pool[0], 1'b0, 1'b1, 64'sd900000, 1'b1, 64'sd900000, 1'b1, 16'd2));
    send_item(pkt(id_pool[5], 1'b0, 1'b1, 64'sd900000, 1'b1, 64'sd0, 1'b0, 16'd2));
    send_item(pkt(id_pool[5], 1'b0, 1'b1, 64'sd0, 1'b0, 64'sd0, 1'b0, 16'd2));
    scr_cnt = 16'd2;
    tbase   = 40000;
  endtask

  // configuration extremes with traffic in between
  task automatic test_config_sweep();
    write_reg(CFG_VIDEO_PERIOD, 47'd1);
    run_traffic(60, 10);
    write_reg(CFG_VIDEO_PERIOD, 47'hFF_FFFF);
    run_traffic(60, 10);
    write_reg(CFG_VIDEO_ID, 47'h0);
    run_traffic(40, 10);
    write_reg(CFG_VIDEO_ID, 47'hFFFF);
    run_traffic(40, 10);
    write_reg(CFG_VIDEO_ID, {31'd0, VIDEO_ID_RST});
    write_reg(CFG_VIDEO_PERIOD, {23'd0, PERIOD_RST});
  endtask

  // start point: dropped until a rebased presentation time reaches it
  task automatic test_start_point();
    write_reg(CFG_START_POINT, 47'h7FFF_FFFF_FFFF);
    run_traffic(30, 10);
    write_reg(CFG_START_POINT, 47'd1);
    run_traffic(60, 10);
    write_reg(CFG_START_POINT, 47'd0);
  endtask

  // receiver held off long enough for the core to stall its input
  task automatic test_back_pressure();
    hold_left = 300;
    run_traffic(40, 5);
    drain();
    run_traffic(40, 5);
  endtask

  // new streams until the table runs out of entries
  task automatic test_table_full();
    for (int k = 0; k < 20; k++) begin
      tbase += 1000;
      send_item(pkt(16'h1000 + k[15:0], 1'b0, 1'b1, tbase, 1'b1, tbase, 1'b1, scr_cnt));
    end
    send_item(pkt(16'h2000, 1'b0, 1'b1, tbase, 1'b1, 64'sd0, 1'b0, scr_cnt));
    run_traffic(60, 10);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    err_cnt       = 0;
    hold_left     = 0;
    stall_left    = 0;
    idling        = 1'b1;
    vid_id        = VIDEO_ID_RST;
    vid_period    = PERIOD_RST;
    start_pt      = '0;
    load_video_entry();
    tbl_cnt       = 1;
    rebase_ofs    = 0;
    scr_seen      = '0;
    first_seen    = 1'b0;
    audio_seen    = 1'b0;
    start_hit     = 1'b1;
    fwd_cnt       = '0;
    id_pool       = '{VIDEO_ID_RST, 16'h00C0, 16'h00C1, 16'h00E1, 16'h0BD0, 16'h0BD1};
    scr_cnt       = '0;
    tbase         = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_time_zero();
    run_traffic(100, 10);
    test_config_sweep();
    test_start_point();
    test_back_pressure();
    test_table_full();
    // last stretch without idling
    drain();
    idling = 1'b0;
    run_traffic(60, 10);

    drain();
    if (err_cnt == 0) begin
      $display("** stream_timestamp_rebaser_core: PASSED **");
    end else begin
      $display("** stream_timestamp_rebaser_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/stsr_pkg.sv
hdl/stsr_chan_if.sv
hdl/stsr_ram.sv
hdl/stream_timestamp_rebaser_core.sv
tb/sv/tb_top.sv
